/* hw/rtl/qpe_pkg.sv */
// ----------------------------------------------------------------------------
// qpe_pkg
// Types and character constants shared by the query parameter extractor.
// ----------------------------------------------------------------------------
package qpe_pkg;

    localparam int unsigned NAME_BYTES = 8;
    localparam int unsigned NAME_W     = NAME_BYTES * 8;

    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [31:0] MAG_CAP = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        CFG_NAME_CHARS = 2'd0,
        CFG_NAME_LEN   = 2'd1
    } t_cfg_idx;

    typedef enum logic [4:0] {
        MODE_PRE   = 5'b00001,
        MODE_MATCH = 5'b00010,
        MODE_SKIP  = 5'b00100,
        MODE_VALUE = 5'b01000,
        MODE_DONE  = 5'b10000
    } t_mode;

    typedef enum logic [2:0] {
        PH_SPACE  = 3'b001,
        PH_DIGITS = 3'b010,
        PH_STOP   = 3'b100
    } t_phase;

    typedef struct packed {
        logic [7:0] url_byte;
        logic       end_of_url;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         value_byte;
        logic               value_byte_valid;
        logic               url_done;
        logic               param_found;
        logic signed [31:0] int_value;
    } t_out_item;

endpackage

/* hw/rtl/qpe_if.sv */
// ----------------------------------------------------------------------------
// qpe channel interfaces
// Valid/ready channels for url bytes, results and configuration writes.
// ----------------------------------------------------------------------------
interface qpe_in_if;
    logic              valid;
    logic              ready;
    qpe_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface qpe_out_if;
    logic               valid;
    logic               ready;
    qpe_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface qpe_cfg_if;
    logic                      valid;
    logic                      ready;
    qpe_pkg::t_cfg_idx         idx;
    logic [qpe_pkg::NAME_W-1:0] wdata;
    modport source (output valid, output idx, output wdata, input ready);
    modport sink   (input valid, input idx, input wdata, output ready);
endinterface

/* hw/rtl/query_param_extractor.sv */
// an accepted url byte's result is loaded into the output register on the edge that accepts it
// throughput: one byte per cycle while the result side takes a transaction each cycle
// the output register is the only buffer, so input ready follows output ready
// reset: synchronous active-low i_rst_n clears parse state, name to zero, length to one
// ----------------------------------------------------------------------------
// query_param_extractor
// Scans a url byte stream for a named query parameter, flags its value bytes
// and converts the value to a saturating signed 32-bit integer.
// ----------------------------------------------------------------------------
module query_param_extractor #(
    parameter int unsigned MAX_NAME_LEN = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qpe_cfg_if.sink     i_cfg,
    qpe_in_if.sink      i_url,
    qpe_out_if.source   o_res
);
    import qpe_pkg::*;

    localparam logic [3:0] MaxLen = 4'(MAX_NAME_LEN);

    logic [NAME_W-1:0] r_name_chars;
    logic [3:0]        r_name_len;

    t_mode       r_mode,  n_mode;
    logic [3:0]  r_pos,   n_pos;
    logic        r_found, n_found;
    logic [31:0] r_acc,   n_acc;
    logic        r_neg,   n_neg;
    t_phase      r_phase, n_phase;

    logic        r_out_valid;
    t_out_item   r_out, n_out;

    logic        in_acc;
    logic [7:0]  b;
    logic [3:0]  len;
    logic [7:0]  expect_byte;
    logic        is_digit;
    logic        is_ws;
    logic [35:0] mag_next;
    logic        valid_byte;

    assign i_cfg.ready = 1'b1;
    assign i_url.ready = !r_out_valid || o_res.ready;
    assign in_acc      = i_url.valid && i_url.ready;

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    assign b        = i_url.data.url_byte;
    assign len      = (r_name_len > MaxLen) ? MaxLen : r_name_len;
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign is_ws    = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    assign mag_next = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                    + {32'b0, 4'(b - CH_ZERO)};

    always_comb begin
        if (r_pos < len) begin
            expect_byte = r_name_chars[r_pos[2:0]*8 +: 8];
        end else begin
            expect_byte = CH_EQ;
        end
    end

    always_comb begin
        n_mode     = r_mode;
        n_pos      = r_pos;
        n_found    = r_found;
        n_acc      = r_acc;
        n_neg      = r_neg;
        n_phase    = r_phase;
        valid_byte = 1'b0;
        case (r_mode)
            MODE_PRE: begin
                if (b == CH_QMARK) begin
                    n_mode = MODE_MATCH;
                    n_pos  = 4'd0;
                end
            end
            MODE_MATCH: begin
                if (b == CH_AMP) begin
                    n_pos = 4'd0;
                end else if (len == 4'd0) begin
                    n_mode = MODE_SKIP;
                end else if (b != expect_byte) begin
                    n_mode = MODE_SKIP;
                end else if (r_pos >= len) begin
                    n_found = 1'b1;
                    n_mode  = MODE_VALUE;
                end else begin
                    n_pos = r_pos + 4'd1;
                end
            end
            MODE_SKIP: begin
                if (b == CH_AMP) begin
                    n_mode = MODE_MATCH;
                    n_pos  = 4'd0;
                end
            end
            MODE_VALUE: begin
                if (b == CH_AMP) begin
                    n_mode = MODE_DONE;
                end else begin
                    valid_byte = 1'b1;
                    if (r_phase != PH_STOP) begin
                        if (is_digit) begin
                            n_acc   = (mag_next > {4'b0, MAG_CAP}) ? MAG_CAP
                                                                  : mag_next[31:0];
                            n_phase = PH_DIGITS;
                        end else if (r_phase == PH_SPACE && is_ws) begin
                            n_phase = PH_SPACE;
                        end else if (r_phase == PH_SPACE
                                     && (b == CH_PLUS || b == CH_MINUS)) begin
                            n_neg   = (b == CH_MINUS);
                            n_phase = PH_DIGITS;
                        end else begin
                            n_phase = PH_STOP;
                        end
                    end
                end
            end
            MODE_DONE: begin
                n_mode = MODE_DONE;
            end
            default: begin
                n_mode = MODE_PRE;
            end
        endcase
    end

    always_comb begin
        n_out.value_byte       = valid_byte ? b : 8'd0;
        n_out.value_byte_valid = valid_byte;
        n_out.url_done         = i_url.data.end_of_url;
        n_out.param_found      = n_found;
        if (!n_found) begin
            n_out.int_value = '0;
        end else if (n_neg) begin
            n_out.int_value = 32'd0 - n_acc;
        end else if (n_acc >= MAG_CAP) begin
            n_out.int_value = INT_MAX;
        end else begin
            n_out.int_value = n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_chars <= '0;
            r_name_len   <= 4'd1;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.idx)
                CFG_NAME_CHARS: r_name_chars <= i_cfg.wdata;
                CFG_NAME_LEN:   r_name_len   <= i_cfg.wdata[3:0];
                default: begin
                    r_name_len <= r_name_len;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_PRE;
            r_pos   <= 4'd0;
            r_found <= 1'b0;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_phase <= PH_SPACE;
        end else if (in_acc) begin
            if (i_url.data.end_of_url) begin
                r_mode  <= MODE_PRE;
                r_pos   <= 4'd0;
                r_found <= 1'b0;
                r_acc   <= '0;
                r_neg   <= 1'b0;
                r_phase <= PH_SPACE;
            end else begin
                r_mode  <= n_mode;
                r_pos   <= n_pos;
                r_found <= n_found;
                r_acc   <= n_acc;
                r_neg   <= n_neg;
                r_phase <= n_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= n_out;
        end
    end

    // found flag tracks the value and done modes
    a_found_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found == (r_mode == MODE_VALUE || r_mode == MODE_DONE))
        else $error("found flag out of step with parse mode");

    // last byte of a url returns parsing to the start
    a_url_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_url.data.end_of_url |=> r_mode == MODE_PRE && !r_found
            && r_acc == 32'd0 && r_phase == PH_SPACE)
        else $error("url state not cleared after last byte");

    // no value or integer before the name is matched
    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.param_found |->
            r_out.int_value == 32'sd0 && !r_out.value_byte_valid)
        else $error("value reported without a match");

    // magnitude never exceeds the saturation cap
    a_mag_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc <= MAG_CAP)
        else $error("accumulator above saturation limit");

    // match position never runs past the name and its equals sign
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= MaxLen)
        else $error("match position out of range");

endmodule
